FILE: rtl/jdc_pkg.sv
// ============================================================================
// jdc_pkg - shared types and constants of the Julian day date converter
// Field widths, word layouts, calendar constants and the small constant
// tables used by the date and day number datapaths.
// ============================================================================
package jdc_pkg;

    // Number of register stages from the input word to the output register.
    localparam int NSTG = 8;

    // Field widths.
    localparam int OP_W    = 1;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int JDN_W   = 23;

    // Input word layout: year, month, day, day number from bit 0 up.
    localparam int S_YEAR_LSB  = 0;
    localparam int S_MONTH_LSB = S_YEAR_LSB + YEAR_W;
    localparam int S_DAY_LSB   = S_MONTH_LSB + MONTH_W;
    localparam int S_JDN_LSB   = S_DAY_LSB + DAY_W;
    localparam int S_USED_W    = S_JDN_LSB + JDN_W;
    localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;

    // Output word layout: day number, year, month, day from bit 0 up.
    localparam int M_JDN_LSB   = 0;
    localparam int M_YEAR_LSB  = M_JDN_LSB + JDN_W;
    localparam int M_MONTH_LSB = M_YEAR_LSB + YEAR_W;
    localparam int M_DAY_LSB   = M_MONTH_LSB + MONTH_W;
    localparam int M_USED_W    = M_DAY_LSB + DAY_W;
    localparam int M_TDATA_W   = ((M_USED_W + 7) / 8) * 8;

    // Opcodes.
    localparam logic OP_DATE_TO_JDN = 1'b0;
    localparam logic OP_JDN_TO_DATE = 1'b1;

    // Date checks and two-digit year expansion.
    localparam int CENT_SPAN   = 100;
    localparam int PIVOT_YEAR  = 50;
    localparam int BASE_LATE   = 2000;
    localparam int BASE_EARLY  = 1900;
    localparam int YEAR_MAX    = 9999;
    localparam int YEAR_MONTHS = 12;
    localparam int MONTH_SHIFT = 2;

    // Forward formula constants.
    localparam int FWD_YEAR_OFS = 4800;
    localparam int FWD_CENT_OFS = 4900;
    localparam int QUAD_DAYS    = 1461;
    localparam int FWD_MON_NUM  = 367;
    localparam int FWD_BIAS     = 32075;
    localparam int CENT_RECIP   = 5243;   // x / 100 == (x * 5243) >> 19 for x below 43699
    localparam int CENT_SHIFT   = 19;

    // Inverse formula constants.
    localparam int JDN_MIN     = 1721426;
    localparam int JDN_MAX     = 5373484;
    localparam int INV_OFS     = 68569;
    localparam int QC_DAYS     = 146097;  // days in 400 years
    localparam int QC_SHIFT    = 25;
    localparam int QC_RECIP    = (1 << QC_SHIFT) / QC_DAYS;
    localparam int CY_NUM      = 4000;
    localparam int CY_DEN      = 1461001;
    localparam int CY_SHIFT    = 28;
    localparam int CY_RECIP    = (1 << CY_SHIFT) / CY_DEN;
    localparam int CY_MUL      = CY_NUM * CY_RECIP;
    localparam int MON_NUM     = 2447;
    localparam int MON_DEN     = 80;
    localparam int INV_DAY_OFS = 31;
    localparam int BASE_CENT   = 49;
    localparam int J2_MAX      = 12;
    localparam int J2_JAN      = 11;      // month index of January in the March-based count

    // Pipeline control between the handshake logic and the datapaths.
    typedef struct packed {
        logic [NSTG-1:0] ld;   // stage k takes a new word
    } pipe_ctl_t;

    typedef logic [15:0][8:0] tbl9_t;

    // Days before month index mm of the March-based year: (367 * mm) / 12.
    function automatic tbl9_t build_mon_tbl();
        tbl9_t tbl;
        for (int mm = 0; mm < 16; mm++) begin
            tbl[mm] = 9'((FWD_MON_NUM * mm) / YEAR_MONTHS);
        end
        return tbl;
    endfunction

    // Day offset of month index j2: (2447 * j2) / 80.
    function automatic tbl9_t build_doff_tbl();
        tbl9_t tbl;
        for (int j = 0; j < 16; j++) begin
            tbl[j] = 9'((MON_NUM * j) / MON_DEN);
        end
        return tbl;
    endfunction

    // Smallest l with (80 * l) / 2447 >= t.
    function automatic tbl9_t build_thr_tbl();
        tbl9_t tbl;
        for (int t = 0; t < 16; t++) begin
            tbl[t] = 9'((MON_NUM * t + MON_DEN - 1) / MON_DEN);
        end
        return tbl;
    endfunction

    localparam tbl9_t MON_TBL  = build_mon_tbl();
    localparam tbl9_t DOFF_TBL = build_doff_tbl();
    localparam tbl9_t THR_TBL  = build_thr_tbl();

endpackage

FILE: rtl/jdc_ctrl.sv
// ============================================================================
// jdc_ctrl - pipeline handshake control
// Keeps a valid bit per stage and lets each stage take a word whenever it is
// empty or its successor moves, so bubbles close up behind a stalled output.
// ============================================================================
module jdc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output jdc_pkg::pipe_ctl_t ctl
);
    import jdc_pkg::*;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] vin;
    logic [NSTG:0]   rdy;

    // Ready ripples back from the output; a stage moves when it is empty
    // or the stage after it moves.
    always_comb begin
        rdy[NSTG] = m_tready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vin = {vld_reg[NSTG-2:0], s_tvalid};
        for (int k = 0; k < NSTG; k++) begin
            vld_next[k] = rdy[k] ? vin[k] : vld_reg[k];
        end
        ctl.ld = rdy[NSTG-1:0] & vin;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[NSTG-1];

`ifndef ASSERT_OFF
    // Every word offered to a stage that moves lands in that stage.
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        ((vin & rdy[NSTG-1:0]) != '0) |=>
        ((vld_reg & $past(vin & rdy[NSTG-1:0])) == $past(vin & rdy[NSTG-1:0])))
        else $error("jdc_ctrl: a word offered to a moving stage was dropped");

    // A stage whose successor is blocked keeps its word.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ((vld_reg & ~rdy[NSTG:1]) != '0) |=>
        ((vld_reg & $past(vld_reg & ~rdy[NSTG:1])) == $past(vld_reg & ~rdy[NSTG:1])))
        else $error("jdc_ctrl: a blocked stage lost its word");

    // A moving stage fed by an empty one becomes empty.
    a_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        ((~vin & rdy[NSTG-1:0]) != '0) |=>
        ((vld_reg & $past(~vin & rdy[NSTG-1:0])) == '0))
        else $error("jdc_ctrl: a stage became valid from a bubble");
`endif

endmodule

FILE: rtl/jdc_fwd.sv
// ============================================================================
// jdc_fwd - date to Julian day number datapath
// Checks and expands the date, evaluates the day number in three stages and
// carries the result down a delay line to the output stage.
// ============================================================================
module jdc_fwd (
    input  logic                           aclk,
    input  jdc_pkg::pipe_ctl_t             ctl,
    input  logic                           opcode,
    input  logic [jdc_pkg::YEAR_W-1:0]     date_year,
    input  logic [jdc_pkg::MONTH_W-1:0]    date_month,
    input  logic [jdc_pkg::DAY_W-1:0]      date_day,
    output logic [jdc_pkg::JDN_W-1:0]      day_number_out,
    output logic                           bad_out
);
    import jdc_pkg::*;

    localparam int FWD_DONE = 2;   // stage index where the day number is final

    // Stage 1 signals.
    logic [YEAR_W-1:0]  year_exp;
    logic               date_ok;
    logic               early;
    logic [YEAR_W-1:0]  f1_yy_next, f1_cx_next;
    logic [MONTH_W-1:0] f1_mm_next;
    logic [YEAR_W-1:0]  f1_yy_reg, f1_cx_reg;
    logic [MONTH_W-1:0] f1_mm_reg;
    logic [DAY_W-1:0]   f1_dd_reg;
    logic               f1_ok_reg, f1_bad_reg;

    // Stage 2 signals.
    logic [24:0]        a_prod;
    logic [26:0]        cent_prod;
    logic [JDN_W-1:0]   f2_a_reg;
    logic [8:0]         f2_b_reg;
    logic [7:0]         f2_cent_reg;
    logic [DAY_W-1:0]   f2_dd_reg;
    logic               f2_ok_reg, f2_bad_reg;

    // Stage 3 and delay line.
    logic [9:0]         c_prod;
    logic [23:0]        jsum;
    logic [JDN_W-1:0]   jn_next;
    logic [JDN_W-1:0]   jn_reg  [FWD_DONE:NSTG-1];
    logic               bad_reg [FWD_DONE:NSTG-1];

    // Two-digit year expansion, date check and March-based year and month.
    always_comb begin
        year_exp = date_year;
        if (date_year != '0 && date_year < YEAR_W'(CENT_SPAN)) begin
            year_exp = (date_year < YEAR_W'(PIVOT_YEAR)) ? date_year + YEAR_W'(BASE_LATE)
                                                         : date_year + YEAR_W'(BASE_EARLY);
        end
        date_ok = (year_exp != '0) && (year_exp <= YEAR_W'(YEAR_MAX)) &&
                  (date_month != '0) && (date_month <= MONTH_W'(YEAR_MONTHS)) &&
                  (date_day != '0);
        early      = (date_month <= MONTH_W'(MONTH_SHIFT));
        f1_yy_next = year_exp + YEAR_W'(FWD_YEAR_OFS) - YEAR_W'(early);
        f1_cx_next = year_exp + YEAR_W'(FWD_CENT_OFS) - YEAR_W'(early);
        f1_mm_next = early ? date_month + MONTH_W'(YEAR_MONTHS - MONTH_SHIFT)
                           : date_month - MONTH_W'(MONTH_SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld[0]) begin
            f1_yy_reg  <= f1_yy_next;
            f1_cx_reg  <= f1_cx_next;
            f1_mm_reg  <= f1_mm_next;
            f1_dd_reg  <= date_day;
            f1_ok_reg  <= (opcode == OP_DATE_TO_JDN) && date_ok;
            f1_bad_reg <= (opcode == OP_DATE_TO_JDN) && !date_ok;
        end
    end

    // Four-year day count and century number by reciprocal.
    always_comb begin
        a_prod    = 25'(f1_yy_reg) * 25'(QUAD_DAYS);
        cent_prod = 27'(f1_cx_reg) * 27'(CENT_RECIP);
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld[1]) begin
            f2_a_reg    <= a_prod[24:2];
            f2_b_reg    <= MON_TBL[f1_mm_reg];
            f2_cent_reg <= cent_prod[CENT_SHIFT +: 8];
            f2_dd_reg   <= f1_dd_reg;
            f2_ok_reg   <= f1_ok_reg;
            f2_bad_reg  <= f1_bad_reg;
        end
    end

    // Sum of the terms, zero unless the date was accepted.
    always_comb begin
        c_prod  = 10'(f2_cent_reg) * 10'd3;
        jsum    = 24'(f2_dd_reg) + 24'(f2_a_reg) + 24'(f2_b_reg)
                - 24'(c_prod[9:2]) - 24'(FWD_BIAS);
        jn_next = f2_ok_reg ? jsum[JDN_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld[FWD_DONE]) begin
            jn_reg[FWD_DONE]  <= jn_next;
            bad_reg[FWD_DONE] <= f2_bad_reg;
        end
        for (int k = FWD_DONE + 1; k < NSTG; k++) begin
            if (ctl.ld[k]) begin
                jn_reg[k]  <= jn_reg[k-1];
                bad_reg[k] <= bad_reg[k-1];
            end
        end
    end

    assign day_number_out = jn_reg[NSTG-1];
    assign bad_out        = bad_reg[NSTG-1];

endmodule

FILE: rtl/jdc_inv.sv
// ============================================================================
// jdc_inv - Julian day number to date datapath
// Eight stages: two constant divisions, each as a reciprocal estimate and a
// single correction, then the year, month and day assembly.
// ============================================================================
module jdc_inv (
    input  logic                           aclk,
    input  jdc_pkg::pipe_ctl_t             ctl,
    input  logic                           opcode,
    input  logic [jdc_pkg::JDN_W-1:0]      day_number_in,
    output logic [jdc_pkg::YEAR_W-1:0]     out_year,
    output logic [jdc_pkg::MONTH_W-1:0]    out_month,
    output logic [jdc_pkg::DAY_W-1:0]      out_day,
    output logic                           bad_out
);
    import jdc_pkg::*;

    // Control flags travel with the word through stages 1 to 7.
    logic [NSTG-2:0] ok_reg, bad_reg;

    // Stage 1: shifted day number and quotient estimate for 400-year cycles.
    logic [23:0] l_sum;
    logic [24:0] x1;
    logic [32:0] q0_prod;
    logic        in_rng;
    logic [24:0] s1_x1_reg;
    logic [7:0]  s1_q0_reg;

    // Stage 2: remainder of the estimate.
    logic [25:0] qd_prod, r0_w;
    logic [7:0]  s2_q0_reg;
    logic [18:0] s2_r0_reg;

    // Stage 3: corrected cycle count and day within the cycle.
    logic        ge_qc;
    logic [18:0] r_fix;
    logic [7:0]  s3_n_reg;
    logic [15:0] s3_l2_reg;

    // Stage 4: quotient estimate for years within the cycle.
    logic [16:0] lp;
    logic [36:0] qi_prod;
    logic [7:0]  s4_n_reg;
    logic [15:0] s4_l2_reg;
    logic [27:0] s4_x2_reg;
    logic [6:0]  s4_qi0_reg;

    // Stage 5: remainder of that estimate.
    logic [27:0] qd2_prod, ri0_w;
    logic [7:0]  s5_n_reg;
    logic [15:0] s5_l2_reg;
    logic [6:0]  s5_qi0_reg;
    logic [21:0] s5_ri0_reg;

    // Stage 6: corrected year within the cycle.
    logic [7:0]  s6_n_reg;
    logic [15:0] s6_l2_reg;
    logic [6:0]  s6_i_reg;

    // Stage 7: day within the March-based year and base year.
    logic [17:0] ip_prod;
    logic [16:0] l3_w;
    logic [7:0]  n_diff;
    logic [YEAR_W-1:0] yb_w;
    logic [8:0]  s7_l3_reg;
    logic [YEAR_W-1:0] s7_yb_reg;

    // Stage 8: month index, day, month, year.
    logic [3:0]         j2;
    logic [8:0]         d_w;
    logic               k_jan;
    logic [MONTH_W-1:0] m_w;
    logic [YEAR_W-1:0]  y_w;
    logic [YEAR_W-1:0]  y_reg;
    logic [MONTH_W-1:0] m_reg;
    logic [DAY_W-1:0]   d_reg;
    logic               bad_o_reg;

    always_comb begin
        l_sum   = 24'(day_number_in) + 24'(INV_OFS);
        x1      = {l_sum[22:0], 2'b00};
        q0_prod = 33'(x1) * 33'(QC_RECIP);
        in_rng  = (day_number_in >= JDN_W'(JDN_MIN)) && (day_number_in <= JDN_W'(JDN_MAX));
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld[0]) begin
            s1_x1_reg  <= x1;
            s1_q0_reg  <= q0_prod[QC_SHIFT +: 8];
        end
    end

    always_comb begin
        qd_prod = 26'(s1_q0_reg) * 26'(QC_DAYS);
        r0_w    = 26'(s1_x1_reg) - qd_prod;
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld[1]) begin
            s2_q0_reg <= s1_q0_reg;
            s2_r0_reg <= r0_w[18:0];
        end
    end

    // The estimate is low by at most one; one compare and subtract fixes it.
    // The day within the cycle is the remainder divided by four.
    always_comb begin
        ge_qc = (s2_r0_reg >= 19'(QC_DAYS));
        r_fix = ge_qc ? s2_r0_reg - 19'(QC_DAYS) : s2_r0_reg;
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld[2]) begin
            s3_n_reg  <= s2_q0_reg + 8'(ge_qc);
            s3_l2_reg <= r_fix[17:2];
        end
    end

    always_comb begin
        lp      = 17'(s3_l2_reg) + 17'd1;
        qi_prod = 37'(lp) * 37'(CY_MUL);
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld[3]) begin
            s4_n_reg   <= s3_n_reg;
            s4_l2_reg  <= s3_l2_reg;
            s4_x2_reg  <= 28'(lp) * 28'(CY_NUM);
            s4_qi0_reg <= qi_prod[CY_SHIFT +: 7];
        end
    end

    always_comb begin
        qd2_prod = 28'(s4_qi0_reg) * 28'(CY_DEN);
        ri0_w    = s4_x2_reg - qd2_prod;
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld[4]) begin
            s5_n_reg   <= s4_n_reg;
            s5_l2_reg  <= s4_l2_reg;
            s5_qi0_reg <= s4_qi0_reg;
            s5_ri0_reg <= ri0_w[21:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld[5]) begin
            s6_n_reg  <= s5_n_reg;
            s6_l2_reg <= s5_l2_reg;
            s6_i_reg  <= s5_qi0_reg + 7'(s5_ri0_reg >= 22'(CY_DEN));
        end
    end

    always_comb begin
        ip_prod = 18'(s6_i_reg) * 18'(QUAD_DAYS);
        l3_w    = 17'(s6_l2_reg) + 17'(INV_DAY_OFS) - 17'(ip_prod[17:2]);
        n_diff  = s6_n_reg - 8'(BASE_CENT);
        yb_w    = YEAR_W'(n_diff) * YEAR_W'(CENT_SPAN) + YEAR_W'(s6_i_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld[6]) begin
            s7_l3_reg <= l3_w[8:0];
            s7_yb_reg <= yb_w;
        end
    end

    // Flags of stages 1 to 7.
    always_ff @(posedge aclk) begin
        if (ctl.ld[0]) begin
            ok_reg[0]  <= (opcode == OP_JDN_TO_DATE) && in_rng;
            bad_reg[0] <= (opcode == OP_JDN_TO_DATE) && !in_rng;
        end
        for (int k = 1; k < NSTG - 1; k++) begin
            if (ctl.ld[k]) begin
                ok_reg[k]  <= ok_reg[k-1];
                bad_reg[k] <= bad_reg[k-1];
            end
        end
    end

    // Month index from monotonic thresholds, then the date fields.
    always_comb begin
        j2 = '0;
        for (int t = 1; t <= J2_MAX; t++) begin
            if (s7_l3_reg >= THR_TBL[t]) begin
                j2 = 4'(t);
            end
        end
        d_w   = s7_l3_reg - DOFF_TBL[j2];
        k_jan = (j2 >= 4'(J2_JAN));
        m_w   = k_jan ? j2 - 4'(YEAR_MONTHS - MONTH_SHIFT) : j2 + 4'(MONTH_SHIFT);
        y_w   = s7_yb_reg + YEAR_W'(k_jan);
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld[NSTG-1]) begin
            y_reg     <= ok_reg[NSTG-2] ? y_w : '0;
            m_reg     <= ok_reg[NSTG-2] ? m_w : '0;
            d_reg     <= ok_reg[NSTG-2] ? d_w[DAY_W-1:0] : '0;
            bad_o_reg <= bad_reg[NSTG-2];
        end
    end

    assign out_year  = y_reg;
    assign out_month = m_reg;
    assign out_day   = d_reg;
    assign bad_out   = bad_o_reg;

endmodule

FILE: rtl/julian_day_date_converter_unit.sv
// Throughput: one word per cycle while the output is not held; the eight-stage
// pipeline of the day-number-to-date path sets the depth, and the date-to-day-number
// path is delayed to match it.
// A held output blocks only the stages behind it that are full; empty stages keep taking words.
// Reset: aresetn, synchronous and active low, clears all stage valid bits; no data is reset.
// ============================================================================
// julian_day_date_converter_unit - Gregorian date and Julian day number converter
// Opcode in s_tuser selects date to day number or day number to date;
// rejected operands raise the flag in m_tuser and give zero fields.
// ============================================================================
module julian_day_date_converter_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [jdc_pkg::S_TDATA_W-1:0]    s_tdata,   // date_year, date_month, date_day,
                                                        // day_number_in, zero fill
    input  logic [0:0]                       s_tuser,   // opcode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [jdc_pkg::M_TDATA_W-1:0]    m_tdata,   // day_number_out, out_year,
                                                        // out_month, out_day, zero fill
    output logic [0:0]                       m_tuser    // bad_input
);
    import jdc_pkg::*;

    pipe_ctl_t          ctl;
    logic [JDN_W-1:0]   day_number_out;
    logic [YEAR_W-1:0]  out_year;
    logic [MONTH_W-1:0] out_month;
    logic [DAY_W-1:0]   out_day;
    logic               fwd_bad, inv_bad;

    // Handshake and stage valid bits.
    jdc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl)
    );

    // Date to day number.
    jdc_fwd u_fwd (
        .aclk           (aclk),
        .ctl            (ctl),
        .opcode         (s_tuser[0]),
        .date_year      (s_tdata[S_YEAR_LSB +: YEAR_W]),
        .date_month     (s_tdata[S_MONTH_LSB +: MONTH_W]),
        .date_day       (s_tdata[S_DAY_LSB +: DAY_W]),
        .day_number_out (day_number_out),
        .bad_out        (fwd_bad)
    );

    // Day number to date.
    jdc_inv u_inv (
        .aclk          (aclk),
        .ctl           (ctl),
        .opcode        (s_tuser[0]),
        .day_number_in (s_tdata[S_JDN_LSB +: JDN_W]),
        .out_year      (out_year),
        .out_month     (out_month),
        .out_day       (out_day),
        .bad_out       (inv_bad)
    );

    // Output word; each path zeroes its fields unless its opcode was taken and its operand accepted.
    always_comb begin
        m_tdata                             = '0;
        m_tdata[M_JDN_LSB +: JDN_W]         = day_number_out;
        m_tdata[M_YEAR_LSB +: YEAR_W]       = out_year;
        m_tdata[M_MONTH_LSB +: MONTH_W]     = out_month;
        m_tdata[M_DAY_LSB +: DAY_W]         = out_day;
        m_tuser[0]                          = fwd_bad | inv_bad;
    end

endmodule

FILE: tb/sv/julian_day_date_converter_unit_test.sv
// ============================================================================
// julian_day_date_converter_unit_test - self-checking bench for the converter
// Sends date and day number words through the stream ports with random gaps
// and output stalls. A scoreboard works out the expected conversion of every
// accepted word and checks each output word against it in order.
// ============================================================================
module julian_day_date_converter_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import jdc_pkg::*;

    // One input word as its separate fields.
    typedef struct packed {
        logic               op;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [JDN_W-1:0]   day_number_in;
    } conv_req_t;

    // One output word as its separate fields.
    typedef struct packed {
        logic [JDN_W-1:0]   day_number;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               bad;
    } conv_result_t;

    typedef struct packed {
        conv_req_t    req;
        conv_result_t want;
    } conv_entry_t;

    // Keeps the conversions still owed by the block and checks them in order.
    class conversion_checker;
        conv_entry_t pending_conversions[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        // Fliegel and Van Flandern conversion in both directions.
        function conv_result_t convert_calendar(conv_req_t r);
            conv_result_t res;
            int unsigned  y, m, d, early, yy, mm, cent, l, n, i, j2, k;
            res = '0;
            if (r.op == OP_DATE_TO_JDN) begin
                y = r.year;
                m = r.month;
                d = r.day;
                // Two-digit years pivot at 50.
                if (y > 0 && y < 100) begin
                    y = (y < 50) ? y + 2000 : y + 1900;
                end
                if (y == 0 || y > 9999 || m < 1 || m > 12 || d < 1) begin
                    res.bad = 1'b1;
                end else begin
                    early = (m <= 2) ? 1 : 0;
                    yy    = y + 4800 - early;
                    mm    = m + 12 * early - 2;
                    cent  = (y + 4900 - early) / 100;
                    res.day_number = JDN_W'(d + (1461 * yy) / 4 + (367 * mm) / 12
                                            - (3 * cent) / 4 - 32075);
                end
            end else begin
                if (r.day_number_in < 1721426 || r.day_number_in > 5373484) begin
                    res.bad = 1'b1;
                end else begin
                    l  = r.day_number_in + 68569;
                    n  = (4 * l) / 146097;
                    l  = l - (146097 * n + 3) / 4;
                    i  = (4000 * (l + 1)) / 1461001;
                    l  = l - (1461 * i) / 4 + 31;
                    j2 = (80 * l) / 2447;
                    k  = j2 / 11;
                    res.day   = DAY_W'(l - (2447 * j2) / 80);
                    res.month = MONTH_W'(j2 + 2 - 12 * k);
                    res.year  = YEAR_W'(100 * (n - 49) + i + k);
                end
            end
            return res;
        endfunction

        function void note_input(conv_req_t r);
            conv_entry_t e;
            e.req  = r;
            e.want = convert_calendar(r);
            pending_conversions.push_back(e);
        endfunction

        task report(string msg);
            errors++;
            $display("jdc_tb mismatch: %s", msg);
        endtask

        task check_result(logic [M_TDATA_W-1:0] data, logic [0:0] flag);
            conv_entry_t  e;
            conv_result_t got;
            if (pending_conversions.size() == 0) begin
                report($sformatf("output word %h flag %b with nothing pending", data, flag));
                return;
            end
            e = pending_conversions.pop_front();
            got.day_number = data[M_JDN_LSB +: JDN_W];
            got.year       = data[M_YEAR_LSB +: YEAR_W];
            got.month      = data[M_MONTH_LSB +: MONTH_W];
            got.day        = data[M_DAY_LSB +: DAY_W];
            got.bad        = flag[0];
            if (got.day_number !== e.want.day_number)
                report($sformatf("req %h day number got %0d want %0d",
                                 e.req, got.day_number, e.want.day_number));
            if (got.year !== e.want.year)
                report($sformatf("req %h year got %0d want %0d",
                                 e.req, got.year, e.want.year));
            if (got.month !== e.want.month)
                report($sformatf("req %h month got %0d want %0d",
                                 e.req, got.month, e.want.month));
            if (got.day !== e.want.day)
                report($sformatf("req %h day got %0d want %0d",
                                 e.req, got.day, e.want.day));
            if (got.bad !== e.want.bad)
                report($sformatf("req %h bad flag got %b want %b",
                                 e.req, got.bad, e.want.bad));
        endtask
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;   // date_year, date_month, date_day, day_number_in
    logic [0:0]             s_tuser;   // opcode
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;   // day_number_out, out_year, out_month, out_day
    logic [0:0]             m_tuser;   // bad_input

    conversion_checker ledger;
    bit                tx_quiet;
    bit                rx_quiet;

    julian_day_date_converter_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 aclk = ~aclk;

    // Date word; the unused day number field carries random bits.
    function automatic conv_req_t date_req(int y, int m, int d);
        conv_req_t r;
        r.op            = OP_DATE_TO_JDN;
        r.year          = YEAR_W'(y);
        r.month         = MONTH_W'(m);
        r.day           = DAY_W'(d);
        r.day_number_in = JDN_W'($urandom);
        return r;
    endfunction

    // Day number word; the unused date fields carry random bits.
    function automatic conv_req_t jdn_req(int j);
        conv_req_t r;
        r.op            = OP_JDN_TO_DATE;
        r.year          = YEAR_W'($urandom);
        r.month         = MONTH_W'($urandom);
        r.day           = DAY_W'($urandom);
        r.day_number_in = JDN_W'(j);
        return r;
    endfunction

    // Sends one word after a random gap and notes it once accepted.
    task automatic send_word(conv_req_t r);
        int                   gap;
        logic [S_TDATA_W-1:0] word;
        if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(0, 9);
        word                          = '0;
        word[S_YEAR_LSB +: YEAR_W]    = r.year;
        word[S_MONTH_LSB +: MONTH_W]  = r.month;
        word[S_DAY_LSB +: DAY_W]      = r.day;
        word[S_JDN_LSB +: JDN_W]      = r.day_number_in;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= word;
        s_tuser  <= r.op;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        ledger.note_input(r);
    endtask

    // Stops sending and waits until every pending conversion has come out.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (ledger.pending_conversions.size() > 0) @(posedge aclk);
    endtask

    // Output side: a random stall before each word, quiet stretches now and then.
    initial begin
        int stall;
        m_tready = 1'b0;
        rx_quiet = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
            stall = rx_quiet ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Every accepted output word is checked against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            ledger.check_result(m_tdata, m_tuser);
        end
    end

    // Main stimulus.
    initial begin
        conv_req_t directed[$];
        conv_req_t r;
        int        sel;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        tx_quiet = 1'b0;
        ledger   = new();
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Pivot years, field extremes, rejected dates and a day past month end.
        directed.push_back(date_req(1, 3, 1));
        directed.push_back(date_req(49, 12, 31));
        directed.push_back(date_req(50, 1, 1));
        directed.push_back(date_req(99, 2, 28));
        directed.push_back(date_req(100, 3, 1));
        directed.push_back(date_req(9999, 12, 31));
        directed.push_back(date_req(0, 6, 15));
        directed.push_back(date_req(10000, 6, 15));
        directed.push_back(date_req(16383, 15, 31));
        directed.push_back(date_req(2024, 0, 10));
        directed.push_back(date_req(2024, 13, 10));
        directed.push_back(date_req(2024, 15, 1));
        directed.push_back(date_req(2024, 5, 0));
        directed.push_back(date_req(2023, 2, 31));
        directed.push_back(date_req(2000, 2, 29));
        directed.push_back(date_req(1582, 10, 15));
        directed.push_back(date_req(1999, 12, 31));
        // Day number range edges and out-of-range values.
        directed.push_back(jdn_req(1721426));
        directed.push_back(jdn_req(1721425));
        directed.push_back(jdn_req(5373484));
        directed.push_back(jdn_req(5373485));
        directed.push_back(jdn_req(0));
        directed.push_back(jdn_req(8388607));
        directed.push_back(jdn_req(2451545));
        directed.push_back(jdn_req(2299161));
        foreach (directed[idx]) send_word(directed[idx]);
        drain();

        // Random part: mostly valid operands, with a share of rejected ones.
        for (int n = 0; n < 1200; n++) begin
            if ($urandom_range(0, 1) == 0) begin
                r = date_req(0, 0, 0);
                sel = $urandom_range(0, 99);
                if (sel < 20)      r.year = YEAR_W'($urandom_range(1, 99));
                else if (sel < 92) r.year = YEAR_W'($urandom_range(100, 9999));
                else if (sel < 96) r.year = '0;
                else               r.year = YEAR_W'($urandom_range(10000, 16383));
                if ($urandom_range(0, 9) != 0) begin
                    r.month = MONTH_W'($urandom_range(1, 12));
                end else begin
                    sel = $urandom_range(0, 3);
                    r.month = (sel == 0) ? '0 : MONTH_W'(12 + sel);
                end
                r.day = ($urandom_range(0, 19) != 0) ? DAY_W'($urandom_range(1, 31)) : '0;
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 85)      r = jdn_req($urandom_range(1721426, 5373484));
                else if (sel < 92) r = jdn_req($urandom_range(0, 1721425));
                else               r = jdn_req($urandom_range(5373485, 8388607));
            end
            send_word(r);
            // Let the pipeline empty out completely now and then.
            if (n % 400 == 399) drain();
        end

        drain();
        repeat (NSTG + 4) @(posedge aclk);
        if (ledger.errors == 0) begin
            $display("[julian_day_date_converter_unit] OK");
        end else begin
            $display("[julian_day_date_converter_unit] ERROR");
        end
        $finish;
    end

    // Hard limit on the run time.
    initial begin
        #5_000_000;
        $display("[julian_day_date_converter_unit] ERROR");
        $finish;
    end

endmodule
